>>> rtl/ile_pkg.sv
// Package for the indexed list engine: sizes, request and status codes,
// sequencer states and the structs passed between the sequencer and the top level.
// Depends on nothing.
`default_nettype none

package ile_pkg;

    // Sizes of the list and of the item fields.
    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 2;
    // Width in which positions and the count are compared.
    localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    // Request codes.
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HEAD   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TAIL   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_DONE
    } t_state;

    // Memory access request issued by the sequencer.
    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [VALUE_W-1:0]  wdata;
        logic [ADDR_W-1:0]   raddr;
    } t_mem_req;

    // One finished result.
    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic [STAT_W-1:0]   status;
        logic [CNT_W-1:0]    entry_count;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/ile_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module ile_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]          i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/ile_seq.sv
// Sequencer of the indexed list engine: decodes a request, keeps the entry count
// and moves entries through the list memory one per cycle. Depends on ile_pkg.
`default_nettype none

module ile_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [ile_pkg::MODE_W-1:0]    i_mode,
    input  wire logic [ile_pkg::POS_W-1:0]     i_position,
    input  wire logic [ile_pkg::VALUE_W-1:0]   i_value,
    output logic                               o_idle,
    output ile_pkg::t_mem_req                  o_mem_req,
    input  wire logic [ile_pkg::VALUE_W-1:0]   i_rd_data,
    output logic                               o_res_valid,
    output ile_pkg::t_result                   o_result,
    input  wire logic                          i_res_take
);

    ile_pkg::t_state                 r_state, n_state;
    logic [ile_pkg::CNT_W-1:0]       r_count, n_count;
    logic [ile_pkg::ADDR_W-1:0]      r_idx, n_idx;
    logic [ile_pkg::CNT_W-1:0]       r_left, n_left;
    logic                            r_up, n_up;
    logic                            r_ins, n_ins;
    logic [ile_pkg::ADDR_W-1:0]      r_at, n_at;
    logic [ile_pkg::VALUE_W-1:0]     r_value, n_value;
    logic                            r_wpend, n_wpend;
    logic [ile_pkg::ADDR_W-1:0]      r_waddr, n_waddr;
    logic [ile_pkg::VALUE_W-1:0]     r_rd, n_rd;
    logic [ile_pkg::STAT_W-1:0]      r_st, n_st;

    logic [ile_pkg::CMP_W-1:0]       pos_c;
    logic [ile_pkg::CMP_W-1:0]       cnt_c;
    logic [ile_pkg::CMP_W-1:0]       at_c;
    logic                            list_full;
    logic                            shift_end;

    // Request decode in a common width.
    assign pos_c     = ile_pkg::CMP_W'(i_position);
    assign cnt_c     = ile_pkg::CMP_W'(r_count);
    assign list_full = (r_count == ile_pkg::CNT_W'(ile_pkg::CAPACITY));
    assign shift_end = (r_left == '0) && !r_wpend;

    // Target position of the insert requests.
    always_comb begin
        case (i_mode)
            ile_pkg::MODE_HEAD: at_c = '0;
            ile_pkg::MODE_TAIL: at_c = cnt_c;
            default:            at_c = pos_c;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ile_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_mode == ile_pkg::MODE_READ) begin
                        n_state = (pos_c < cnt_c) ? ile_pkg::S_READ : ile_pkg::S_DONE;
                    end else if (i_mode == ile_pkg::MODE_HEAD
                                 || i_mode == ile_pkg::MODE_TAIL
                                 || i_mode == ile_pkg::MODE_INSERT) begin
                        n_state = (at_c > cnt_c || list_full) ? ile_pkg::S_DONE
                                                              : ile_pkg::S_SHIFT;
                    end else if (i_mode == ile_pkg::MODE_DELETE) begin
                        n_state = (pos_c >= cnt_c) ? ile_pkg::S_DONE : ile_pkg::S_SHIFT;
                    end else begin
                        n_state = ile_pkg::S_DONE;
                    end
                end
            end
            ile_pkg::S_READ: begin
                n_state = ile_pkg::S_DONE;
            end
            ile_pkg::S_SHIFT: begin
                if (shift_end) begin
                    n_state = ile_pkg::S_DONE;
                end
            end
            ile_pkg::S_DONE: begin
                if (i_res_take) begin
                    n_state = ile_pkg::S_IDLE;
                end
            end
            default: n_state = ile_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory requests for each state.
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_left    = r_left;
        n_up      = r_up;
        n_ins     = r_ins;
        n_at      = r_at;
        n_value   = r_value;
        n_wpend   = 1'b0;
        n_waddr   = r_waddr;
        n_rd      = r_rd;
        n_st      = r_st;
        o_mem_req = '{we: 1'b0, waddr: r_waddr, wdata: i_rd_data, raddr: r_idx};
        unique case (r_state)
            ile_pkg::S_IDLE: begin
                o_mem_req.raddr = ile_pkg::ADDR_W'(i_position);
                if (i_start) begin
                    n_rd = '0;
                    n_st = ile_pkg::ST_DONE;
                    if (i_mode == ile_pkg::MODE_READ) begin
                        // The memory read issued now lands in the read state.
                        if (pos_c >= cnt_c) begin
                            n_rd = '1;
                            n_st = ile_pkg::ST_RANGE;
                        end
                    end else if (i_mode == ile_pkg::MODE_HEAD
                                 || i_mode == ile_pkg::MODE_TAIL
                                 || i_mode == ile_pkg::MODE_INSERT) begin
                        // The range check comes before the full check.
                        if (at_c > cnt_c) begin
                            n_st = ile_pkg::ST_RANGE;
                        end else if (list_full) begin
                            n_st = ile_pkg::ST_FULL;
                        end else begin
                            n_up    = 1'b1;
                            n_ins   = 1'b1;
                            n_idx   = ile_pkg::ADDR_W'(r_count - 1'b1);
                            n_left  = ile_pkg::CNT_W'(cnt_c - at_c);
                            n_at    = ile_pkg::ADDR_W'(at_c);
                            n_value = i_value;
                            n_count = r_count + 1'b1;
                        end
                    end else if (i_mode == ile_pkg::MODE_DELETE) begin
                        if (pos_c >= cnt_c) begin
                            n_st = ile_pkg::ST_RANGE;
                        end else begin
                            n_up    = 1'b0;
                            n_ins   = 1'b0;
                            n_idx   = ile_pkg::ADDR_W'(pos_c + 1'b1);
                            n_left  = ile_pkg::CNT_W'(cnt_c - pos_c - 1'b1);
                            n_count = r_count - 1'b1;
                        end
                    end else begin
                        n_st = ile_pkg::ST_RANGE;
                    end
                end
            end
            ile_pkg::S_READ: begin
                n_rd = i_rd_data;
            end
            ile_pkg::S_SHIFT: begin
                // Entry read last cycle is written one place up or down.
                if (r_wpend) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = r_waddr;
                    o_mem_req.wdata = i_rd_data;
                end else if (r_left == '0 && r_ins) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = r_at;
                    o_mem_req.wdata = r_value;
                end
                // Next read of the move.
                if (r_left != '0) begin
                    n_wpend = 1'b1;
                    n_waddr = r_up ? r_idx + 1'b1 : r_idx - 1'b1;
                    n_idx   = r_up ? r_idx - 1'b1 : r_idx + 1'b1;
                    n_left  = r_left - 1'b1;
                end
            end
            ile_pkg::S_DONE: begin
                n_wpend = 1'b0;
            end
            default: n_wpend = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ile_pkg::S_IDLE;
            r_count <= '0;
            r_wpend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_wpend <= n_wpend;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_left  <= n_left;
        r_up    <= n_up;
        r_ins   <= n_ins;
        r_at    <= n_at;
        r_value <= n_value;
        r_waddr <= n_waddr;
        r_rd    <= n_rd;
        r_st    <= n_st;
    end

    assign o_idle      = (r_state == ile_pkg::S_IDLE);
    assign o_res_valid = (r_state == ile_pkg::S_DONE);
    assign o_result    = '{read_value: r_rd, status: r_st, entry_count: r_count};

    // The count never passes the capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ile_pkg::CNT_W'(ile_pkg::CAPACITY))
        else $error("entry count above capacity");

    // No memory write while no request is in progress.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ile_pkg::S_IDLE) |-> !o_mem_req.we)
        else $error("memory write while idle");

    // A started request always leaves the idle state.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == ile_pkg::S_IDLE) |=> (r_state != ile_pkg::S_IDLE))
        else $error("started request did not leave idle");

    // A full status is reported only for a full list.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ile_pkg::S_DONE && r_st == ile_pkg::ST_FULL)
            |-> (r_count == ile_pkg::CNT_W'(ile_pkg::CAPACITY)))
        else $error("full status with a list that is not full");

    // A pending move write never survives to the result.
    a_write_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ile_pkg::S_DONE) |-> !r_wpend)
        else $error("move write pending at result");

endmodule

`default_nettype wire

>>> rtl/indexed_list_engine.sv
// Top level of the indexed list engine: request handshake, list memory,
// sequencer and result register. Depends on ile_pkg, ile_ram and ile_seq.
//
//   Channel   Direction  Handshake          Payload
//   request   in         i_valid / o_stall  i_mode, i_position, i_value
//   result    out        o_valid / i_stall  o_read_value, o_status, o_entry_count
//
// A read passes through the read state on its way to the result register; an
// error or an undefined mode goes there straight from idle. An insert or delete
// moves one entry per cycle through the list memory. The next request can be
// taken in the cycle after the result leaves the sequencer. Reset clears the
// entry count, the sequencer state and the result valid flag; list entries are
// not cleared. A result held in the output register does not stop the next
// request; a finished result waits in the sequencer until the register is free.
`default_nettype none

module indexed_list_engine (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic        [ile_pkg::MODE_W-1:0]    i_mode,
    input  wire logic        [ile_pkg::POS_W-1:0]     i_position,
    input  wire logic signed [ile_pkg::VALUE_W-1:0]   i_value,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed      [ile_pkg::VALUE_W-1:0]   o_read_value,
    output logic             [ile_pkg::STAT_W-1:0]    o_status,
    output logic             [ile_pkg::CNT_W-1:0]     o_entry_count
);

    logic                             seq_idle;
    logic                             start;
    ile_pkg::t_mem_req                mem_req;
    logic [ile_pkg::VALUE_W-1:0]      rd_data;
    logic                             res_valid;
    ile_pkg::t_result                 result;
    logic                             res_take;
    logic                             r_out_valid;
    ile_pkg::t_result                 r_out;

    // A request transaction is taken whenever the sequencer is idle.
    assign o_stall  = !seq_idle;
    assign start    = i_valid && seq_idle;
    assign res_take = !r_out_valid || !i_stall;

    ile_ram #(
        .DEPTH (ile_pkg::CAPACITY),
        .WIDTH (ile_pkg::VALUE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (rd_data)
    );

    ile_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_mode      (i_mode),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_idle      (seq_idle),
        .o_mem_req   (mem_req),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .o_result    (result),
        .i_res_take  (res_take)
    );

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out <= result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_value  = r_out.read_value;
    assign o_status      = r_out.status;
    assign o_entry_count = r_out.entry_count;

endmodule

`default_nettype wire
